[hw/rtl/blm_pkg.sv]
// blm_pkg: shared types, register indexes, reset values and helpers for the
// battery level monitor. No dependencies.
package blm_pkg;

    localparam int CFG_W   = 12;
    localparam int LEVEL_W = 12;
    localparam int CNT_W   = 8;
    localparam int IDX_W   = 3;

    localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST       = 12'd2100;
    localparam logic [LEVEL_W-1:0] RECOVER_LEVEL_RST   = 12'd2300;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL_RST      = 12'd2556;
    localparam logic [LEVEL_W-1:0] FULL_DROP_LEVEL_RST = 12'd2574;
    localparam logic [CNT_W-1:0]   DEBOUNCE_COUNT_RST  = 8'd20;
    localparam logic [CNT_W-1:0]   CNT_MAX             = 8'hFF;

    typedef enum logic [IDX_W-1:0] {
        CFG_LOW_LEVEL       = 3'd0,
        CFG_RECOVER_LEVEL   = 3'd1,
        CFG_FULL_LEVEL      = 3'd2,
        CFG_FULL_DROP_LEVEL = 3'd3,
        CFG_DEBOUNCE_COUNT  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] low_level;
        logic [LEVEL_W-1:0] recover_level;
        logic [LEVEL_W-1:0] full_level;
        logic [LEVEL_W-1:0] full_drop_level;
        logic [CNT_W-1:0]   debounce_count;
    } cfg_t;

    typedef struct packed {
        logic dev_running;
        logic charging;
    } status_t;

    // packed high to low so {flags, level} matches the output beat layout
    typedef struct packed {
        logic restart_full_timer;
        logic restart_shutdown_timer;
        logic drop_charge_full;
        logic battery_full;
        logic battery_low;
    } flags_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
    endfunction

endpackage

[hw/rtl/blm_cfg.sv]
// blm_cfg: threshold and debounce register file.
// Depends on blm_pkg.
module blm_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [blm_pkg::IDX_W-1:0] cfg_index,
    input  logic [blm_pkg::CFG_W-1:0] cfg_data,
    output blm_pkg::cfg_t             cfg
);

    blm_pkg::cfg_t cfg_reg;
    blm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (blm_pkg::cfg_idx_t'(cfg_index))
                blm_pkg::CFG_LOW_LEVEL:       cfg_next.low_level       = cfg_data;
                blm_pkg::CFG_RECOVER_LEVEL:   cfg_next.recover_level   = cfg_data;
                blm_pkg::CFG_FULL_LEVEL:      cfg_next.full_level      = cfg_data;
                blm_pkg::CFG_FULL_DROP_LEVEL: cfg_next.full_drop_level = cfg_data;
                blm_pkg::CFG_DEBOUNCE_COUNT:
                    cfg_next.debounce_count = cfg_data[blm_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_level       <= blm_pkg::LOW_LEVEL_RST;
            cfg_reg.recover_level   <= blm_pkg::RECOVER_LEVEL_RST;
            cfg_reg.full_level      <= blm_pkg::FULL_LEVEL_RST;
            cfg_reg.full_drop_level <= blm_pkg::FULL_DROP_LEVEL_RST;
            cfg_reg.debounce_count  <= blm_pkg::DEBOUNCE_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/blm_accum.sv]
// blm_accum: frame counter plus running sum, min and max of the kept samples.
// Hands the frame totals to the mean stage on the last beat. Depends on blm_pkg.
module blm_accum #(
    parameter int KEPT_SAMPLES = 10,
    parameter int SAMPLE_BITS  = 12,
    parameter int SUM_W        = SAMPLE_BITS + $clog2(KEPT_SAMPLES)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  blm_pkg::status_t       in_status,
    output logic                   tok_valid,
    input  logic                   tok_ready,
    output logic [SUM_W-1:0]       tok_sum,
    output logic [SAMPLE_BITS-1:0] tok_min,
    output logic [SAMPLE_BITS-1:0] tok_max,
    output blm_pkg::status_t       tok_status
);

    localparam int FRAME_LEN = KEPT_SAMPLES + 2;
    localparam int FIDX_W    = $clog2(FRAME_LEN);

    logic [FIDX_W-1:0]      idx_reg,  idx_next;
    logic [SUM_W-1:0]       sum_reg,  sum_next;
    logic [SAMPLE_BITS-1:0] min_reg,  min_next;
    logic [SAMPLE_BITS-1:0] max_reg,  max_next;
    logic                   tok_valid_reg, tok_valid_next;
    logic [SUM_W-1:0]       tok_sum_reg;
    logic [SAMPLE_BITS-1:0] tok_min_reg;
    logic [SAMPLE_BITS-1:0] tok_max_reg;
    blm_pkg::status_t       tok_status_reg;

    logic last, first_kept, kept, accept;

    assign last       = (idx_reg == FIDX_W'(FRAME_LEN - 1));
    assign first_kept = (idx_reg == FIDX_W'(2));
    assign kept       = (idx_reg >= FIDX_W'(2));
    assign in_ready   = !last || !tok_valid_reg || tok_ready;
    assign accept     = in_valid && in_ready;

    always_comb
    begin
        idx_next = idx_reg;
        sum_next = sum_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (accept)
        begin
            idx_next = last ? '0 : idx_reg + 1'b1;
            if (kept)
            begin
                sum_next = first_kept ? SUM_W'(in_sample) : sum_reg + SUM_W'(in_sample);
                min_next = (first_kept || in_sample < min_reg) ? in_sample : min_reg;
                max_next = (first_kept || in_sample > max_reg) ? in_sample : max_reg;
            end
        end
        tok_valid_next = tok_valid_reg && !tok_ready;
        if (accept && last)
            tok_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            sum_reg       <= '0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        max_reg <= max_next;
        if (accept && last)
        begin
            tok_sum_reg    <= sum_next;
            tok_min_reg    <= min_next;
            tok_max_reg    <= max_next;
            tok_status_reg <= in_status;
        end
    end

    assign tok_valid  = tok_valid_reg;
    assign tok_sum    = tok_sum_reg;
    assign tok_min    = tok_min_reg;
    assign tok_max    = tok_max_reg;
    assign tok_status = tok_status_reg;

endmodule

[hw/rtl/blm_mean.sv]
// blm_mean: trimmed mean, (sum - min - max) / (KEPT_SAMPLES - 2), done as an
// exact multiply by a reciprocal and a shift. Depends on blm_pkg.
module blm_mean #(
    parameter int KEPT_SAMPLES = 10,
    parameter int SAMPLE_BITS  = 12,
    parameter int SUM_W        = SAMPLE_BITS + $clog2(KEPT_SAMPLES)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tok_valid,
    output logic                   tok_ready,
    input  logic [SUM_W-1:0]       tok_sum,
    input  logic [SAMPLE_BITS-1:0] tok_min,
    input  logic [SAMPLE_BITS-1:0] tok_max,
    input  blm_pkg::status_t       tok_status,
    output logic                   lvl_valid,
    input  logic                   lvl_ready,
    output logic [SAMPLE_BITS-1:0] level,
    output blm_pkg::status_t       lvl_status
);

    localparam int DIV    = KEPT_SAMPLES - 2;
    localparam int DIV_SH = $clog2(DIV);
    localparam int RCP_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    // ceil(2^(SUM_W+DIV_SH) / DIV): exact quotient for any SUM_W-bit dividend
    localparam longint unsigned RECIP =
        ((64'd1 << (SUM_W + DIV_SH)) + 64'(DIV) - 64'd1) / 64'(DIV);

    logic [SUM_W-1:0]       trimmed;
    logic [PROD_W-1:0]      product;
    logic [SAMPLE_BITS-1:0] level_next;
    logic                   lvl_valid_reg, lvl_valid_next;
    logic [SAMPLE_BITS-1:0] level_reg;
    blm_pkg::status_t       status_reg;
    logic                   take;

    assign tok_ready = !lvl_valid_reg || lvl_ready;
    assign take      = tok_valid && tok_ready;

    always_comb
    begin
        trimmed        = tok_sum - SUM_W'(tok_min) - SUM_W'(tok_max);
        product        = PROD_W'(trimmed) * PROD_W'(RCP_W'(RECIP));
        level_next     = product[SUM_W + DIV_SH +: SAMPLE_BITS];
        lvl_valid_next = take || (lvl_valid_reg && !lvl_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lvl_valid_reg <= 1'b0;
        else
            lvl_valid_reg <= lvl_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            level_reg  <= level_next;
            status_reg <= tok_status;
        end
    end

    assign lvl_valid  = lvl_valid_reg;
    assign level      = level_reg;
    assign lvl_status = status_reg;

endmodule

[hw/rtl/blm_decide.sv]
// blm_decide: debounced low, full and below-full decisions and the output
// register. Depends on blm_pkg.
module blm_decide #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  blm_pkg::cfg_t          cfg,
    input  logic                   lvl_valid,
    output logic                   lvl_ready,
    input  logic [SAMPLE_BITS-1:0] level,
    input  blm_pkg::status_t       lvl_status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_level,
    output blm_pkg::flags_t        out_flags
);

    localparam int CMP_W = (SAMPLE_BITS > blm_pkg::LEVEL_W) ? SAMPLE_BITS : blm_pkg::LEVEL_W;

    logic [blm_pkg::CNT_W-1:0] low_cnt_reg,  low_cnt_next;
    logic [blm_pkg::CNT_W-1:0] full_cnt_reg, full_cnt_next;
    logic [blm_pkg::CNT_W-1:0] drop_cnt_reg, drop_cnt_next;
    logic [blm_pkg::CNT_W-1:0] low_inc, full_inc, drop_inc;
    logic                      low_flag_reg,  low_flag_next;
    logic                      full_flag_reg, full_flag_next;
    logic                      out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]    out_level_reg;
    blm_pkg::flags_t           out_flags_reg, flags_next;
    logic [CMP_W-1:0]          lvl;
    logic                      take, is_low, is_below_full, is_full;

    assign lvl_ready = !out_valid_reg || out_ready;
    assign take      = lvl_valid && lvl_ready;

    always_comb
    begin
        lvl           = CMP_W'(level);
        is_low        = lvl < CMP_W'(cfg.low_level) && !lvl_status.charging
                        && lvl_status.dev_running;
        is_below_full = lvl < CMP_W'(cfg.full_drop_level);
        is_full       = lvl > CMP_W'(cfg.full_level);
        low_inc       = blm_pkg::sat_inc(low_cnt_reg);
        drop_inc      = blm_pkg::sat_inc(drop_cnt_reg);
        full_inc      = blm_pkg::sat_inc(full_cnt_reg);

        low_cnt_next   = low_cnt_reg;
        full_cnt_next  = full_cnt_reg;
        drop_cnt_next  = drop_cnt_reg;
        low_flag_next  = low_flag_reg;
        full_flag_next = full_flag_reg;
        flags_next     = '0;

        if (is_low)
        begin
            low_cnt_next = low_inc;
            if (low_inc >= cfg.debounce_count)
            begin
                flags_next.restart_shutdown_timer = !low_flag_reg;
                low_flag_next = 1'b1;
            end
        end
        else
        begin
            low_cnt_next = '0;
            if (lvl > CMP_W'(cfg.recover_level) || lvl_status.charging)
                low_flag_next = 1'b0;
        end

        if (is_below_full)
        begin
            drop_cnt_next = drop_inc;
            flags_next.drop_charge_full =
                (drop_inc >= cfg.debounce_count) && !lvl_status.charging;
        end
        else
        begin
            drop_cnt_next = '0;
        end

        if (is_full)
        begin
            full_cnt_next = full_inc;
            if (full_inc >= cfg.debounce_count)
            begin
                flags_next.restart_full_timer = !full_flag_reg;
                if (lvl_status.charging)
                    full_flag_next = 1'b1;
            end
        end
        else
        begin
            full_cnt_next  = '0;
            full_flag_next = 1'b0;
        end

        flags_next.battery_low  = low_flag_next;
        flags_next.battery_full = full_flag_next;
        out_valid_next = take || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_cnt_reg   <= '0;
            full_cnt_reg  <= '0;
            drop_cnt_reg  <= '0;
            low_flag_reg  <= 1'b0;
            full_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                low_cnt_reg   <= low_cnt_next;
                full_cnt_reg  <= full_cnt_next;
                drop_cnt_reg  <= drop_cnt_next;
                low_flag_reg  <= low_flag_next;
                full_flag_reg <= full_flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_level_reg <= level;
            out_flags_reg <= flags_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_level = out_level_reg;
    assign out_flags = out_flags_reg;

endmodule

[hw/rtl/battery_level_monitor_core.sv]
// Battery level monitor top level: stream ports, config port, three-stage pipe.
// Depends on blm_pkg, blm_cfg, blm_accum, blm_mean, blm_decide.
//
// Takes one ADC sample beat per clock. Samples are framed in groups of
// KEPT_SAMPLES + 2; the first two of a frame are dropped, and the last beat of
// each frame yields one output beat carrying the trimmed mean (min and max
// removed, divided by KEPT_SAMPLES - 2) and the debounced low, full and
// below-full flags with the timer restart pulses. The accumulate, mean and
// decide registers load in that order, and the decide register drives the
// output beat. Input is only held off when a frame's last beat arrives while
// the pipe is full behind a stalled output. No clearing pass after reset.
module battery_level_monitor_core #(
    parameter int KEPT_SAMPLES = 10,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // sample, charging, dev_running
    input  logic [((SAMPLE_BITS + 9) / 8) * 8 - 1:0] s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // filtered_level, battery_low, battery_full, drop_charge_full,
    // restart_shutdown_timer, restart_full_timer
    output logic [((SAMPLE_BITS + 12) / 8) * 8 - 1:0] m_tdata,
    input  logic                                 cfg_we,
    input  logic [blm_pkg::IDX_W-1:0]            cfg_index,
    input  logic [blm_pkg::CFG_W-1:0]            cfg_data
);

    localparam int OUT_W = ((SAMPLE_BITS + 12) / 8) * 8;
    localparam int SUM_W = SAMPLE_BITS + $clog2(KEPT_SAMPLES);

    blm_pkg::cfg_t          cfg;
    blm_pkg::status_t       in_status, tok_status, lvl_status;
    blm_pkg::flags_t        out_flags;
    logic                   tok_valid, tok_ready, lvl_valid, lvl_ready;
    logic [SUM_W-1:0]       tok_sum;
    logic [SAMPLE_BITS-1:0] tok_min, tok_max, level, out_level;

    assign in_status.charging    = s_tdata[SAMPLE_BITS];
    assign in_status.dev_running = s_tdata[SAMPLE_BITS + 1];

    blm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    blm_accum #(
        .KEPT_SAMPLES (KEPT_SAMPLES),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .SUM_W        (SUM_W)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .in_status  (in_status),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok_sum    (tok_sum),
        .tok_min    (tok_min),
        .tok_max    (tok_max),
        .tok_status (tok_status)
    );

    blm_mean #(
        .KEPT_SAMPLES (KEPT_SAMPLES),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .SUM_W        (SUM_W)
    ) u_mean (
        .clk        (clk),
        .rst_n      (rst_n),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok_sum    (tok_sum),
        .tok_min    (tok_min),
        .tok_max    (tok_max),
        .tok_status (tok_status),
        .lvl_valid  (lvl_valid),
        .lvl_ready  (lvl_ready),
        .level      (level),
        .lvl_status (lvl_status)
    );

    blm_decide #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .lvl_valid  (lvl_valid),
        .lvl_ready  (lvl_ready),
        .level      (level),
        .lvl_status (lvl_status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_level  (out_level),
        .out_flags  (out_flags)
    );

    assign m_tdata = OUT_W'({out_flags, out_level});

endmodule

[sim/tb_top.sv]
// tb_top: self-checking testbench for battery_level_monitor_core.
// Drives sample beats and register writes, predicts each level report and checks it.
// Depends on blm_pkg and the battery_level_monitor_core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEPT_SAMPLES  = 10;
    localparam int SAMPLE_BITS   = 12;
    localparam int LEVEL_W       = blm_pkg::LEVEL_W;
    localparam int CNT_W         = blm_pkg::CNT_W;
    localparam int IDX_W         = blm_pkg::IDX_W;
    localparam int CFG_W         = blm_pkg::CFG_W;
    localparam int FRAME_LEN     = KEPT_SAMPLES + 2;
    localparam int S_W           = ((SAMPLE_BITS + 9) / 8) * 8;
    localparam int M_W           = ((SAMPLE_BITS + 12) / 8) * 8;
    localparam int MAX_SAMPLE    = (1 << SAMPLE_BITS) - 1;
    localparam int MAX_LEVEL     = (1 << LEVEL_W) - 1;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_BEATS   = 40;
    localparam int STEADY_FRAMES = 12;
    localparam int DRAIN_CYCLES  = 6;
    localparam int MAX_REPORTED  = 10;

    typedef struct packed {
        blm_pkg::flags_t    flags;
        logic [LEVEL_W-1:0] level;
    } level_report_t;

    localparam int REP_W = $bits(level_report_t);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   charging;
        logic                   dev_running;
        logic                   checked;
        logic [LEVEL_W-1:0]     exp_level;
        blm_pkg::flags_t        exp_flags;
    } directed_row_t;

    // discarded head beats carry the opposite extreme of the kept ones
    directed_row_t directed_rows [24] = '{
        '{12'd0,    1'b0, 1'b0, 1'b0, 12'd0,    '0},
        '{12'd0,    1'b1, 1'b0, 1'b0, 12'd0,    '0},
        '{12'd4095, 1'b1, 1'b1, 1'b0, 12'd0,    '0},
        '{12'd4095, 1'b0, 1'b1, 1'b0, 12'd0,    '0},
        '{12'd4095, 1'b1, 1'b0, 1'b0, 12'd0,    '0},
        '{12'd4095, 1'b1, 1'b1, 1'b0, 12'd0,    '0},
        '{12'd4095, 1'b0, 1'b0, 1'b0, 12'd0,    '0},
        '{12'd4095, 1'b1, 1'b1, 1'b0, 12'd0,    '0},
        '{12'd4095, 1'b1, 1'b1, 1'b0, 12'd0,    '0},
        '{12'd4095, 1'b0, 1'b1, 1'b0, 12'd0,    '0},
        '{12'd4095, 1'b1, 1'b1, 1'b0, 12'd0,    '0},
        '{12'd4095, 1'b1, 1'b1, 1'b1, 12'd4095, '0},
        '{12'd4095, 1'b1, 1'b0, 1'b0, 12'd0,    '0},
        '{12'd4095, 1'b0, 1'b1, 1'b0, 12'd0,    '0},
        '{12'd0,    1'b1, 1'b1, 1'b0, 12'd0,    '0},
        '{12'd0,    1'b0, 1'b0, 1'b0, 12'd0,    '0},
        '{12'd0,    1'b0, 1'b1, 1'b0, 12'd0,    '0},
        '{12'd0,    1'b1, 1'b0, 1'b0, 12'd0,    '0},
        '{12'd0,    1'b0, 1'b1, 1'b0, 12'd0,    '0},
        '{12'd0,    1'b0, 1'b1, 1'b0, 12'd0,    '0},
        '{12'd0,    1'b1, 1'b1, 1'b0, 12'd0,    '0},
        '{12'd0,    1'b0, 1'b1, 1'b0, 12'd0,    '0},
        '{12'd0,    1'b0, 1'b1, 1'b0, 12'd0,    '0},
        '{12'd0,    1'b0, 1'b1, 1'b1, 12'd0,    '0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata;   // sample, charging, dev_running
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_W-1:0]        m_tdata;   // filtered_level, battery_low, battery_full,
                                      // drop_charge_full, restart_shutdown_timer,
                                      // restart_full_timer
    logic                  cfg_we;
    logic [IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    logic [LEVEL_W-1:0]    thr_low;
    logic [LEVEL_W-1:0]    thr_recover;
    logic [LEVEL_W-1:0]    thr_full;
    logic [LEVEL_W-1:0]    thr_drop;
    logic [CNT_W-1:0]      debounce_need;

    int                    frame_pos;
    int unsigned           acc_sum;
    int unsigned           acc_min;
    int unsigned           acc_max;
    logic [CNT_W-1:0]      low_cnt;
    logic [CNT_W-1:0]      full_cnt;
    logic [CNT_W-1:0]      drop_cnt;
    bit                    low_on;
    bit                    full_on;

    level_report_t         expected_reports [$];
    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    mismatches;
    int                    beats_in;
    int                    reports_seen;
    int                    reg_writes;

    battery_level_monitor_core #(
        .KEPT_SAMPLES (KEPT_SAMPLES),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] cnt);
        return (cnt == blm_pkg::CNT_MAX) ? blm_pkg::CNT_MAX : cnt + 1'b1;
    endfunction

    // trimmed mean over the kept part of a frame, then the three debounced conditions
    task automatic filter_and_debounce(input logic [SAMPLE_BITS-1:0] smp,
                                       input logic chg, input logic run,
                                       output bit produced, output level_report_t rep);
        int unsigned        trimmed;
        logic [LEVEL_W-1:0] lvl;
        produced = 1'b0;
        rep = '0;
        if (frame_pos == 2)
        begin
            acc_sum = smp;
            acc_min = smp;
            acc_max = smp;
        end
        else if (frame_pos > 2)
        begin
            acc_sum += smp;
            if (smp < acc_min)
                acc_min = smp;
            if (smp > acc_max)
                acc_max = smp;
        end
        if (frame_pos < FRAME_LEN - 1)
        begin
            frame_pos++;
        end
        else
        begin
            frame_pos = 0;
            produced = 1'b1;
            trimmed = (acc_sum - acc_min - acc_max) / (KEPT_SAMPLES - 2);
            lvl = trimmed[LEVEL_W-1:0];
            if (lvl < thr_low && !chg && run)
            begin
                low_cnt = bump(low_cnt);
                if (low_cnt >= debounce_need)
                begin
                    rep.flags.restart_shutdown_timer = !low_on;
                    low_on = 1'b1;
                end
            end
            else
            begin
                if (lvl > thr_recover || chg)
                    low_on = 1'b0;
                low_cnt = '0;
            end
            if (lvl < thr_drop)
            begin
                drop_cnt = bump(drop_cnt);
                rep.flags.drop_charge_full = (drop_cnt >= debounce_need) && !chg;
            end
            else
            begin
                drop_cnt = '0;
            end
            if (lvl > thr_full)
            begin
                full_cnt = bump(full_cnt);
                if (full_cnt >= debounce_need)
                begin
                    rep.flags.restart_full_timer = !full_on;
                    if (chg)
                        full_on = 1'b1;
                end
            end
            else
            begin
                full_on = 1'b0;
                full_cnt = '0;
            end
            rep.level = lvl;
            rep.flags.battery_low = low_on;
            rep.flags.battery_full = full_on;
        end
    endtask

    task automatic send_beat(input logic [SAMPLE_BITS-1:0] smp, input logic chg,
                             input logic run, input bit typed_valid,
                             input level_report_t typed);
        bit            produced;
        level_report_t rep;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_W - SAMPLE_BITS - 2){1'b0}}, run, chg, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_in++;
        filter_and_debounce(smp, chg, run, produced, rep);
        if (typed_valid)
            expected_reports.push_back(typed);
        else if (produced)
            expected_reports.push_back(rep);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        reg_writes++;
        unique case (idx)
            blm_pkg::CFG_LOW_LEVEL:       thr_low = data[LEVEL_W-1:0];
            blm_pkg::CFG_RECOVER_LEVEL:   thr_recover = data[LEVEL_W-1:0];
            blm_pkg::CFG_FULL_LEVEL:      thr_full = data[LEVEL_W-1:0];
            blm_pkg::CFG_FULL_DROP_LEVEL: thr_drop = data[LEVEL_W-1:0];
            blm_pkg::CFG_DEBOUNCE_COUNT:  debounce_need = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_thresholds();
        int lo;
        int fu;
        int rec;
        int drp;
        lo = $urandom_range(MAX_LEVEL);
        fu = $urandom_range(MAX_LEVEL);
        rec = lo + int'($urandom_range(400));
        drp = fu + int'($urandom_range(100));
        if (rec > MAX_LEVEL)
            rec = MAX_LEVEL;
        if (drp > MAX_LEVEL)
            drp = MAX_LEVEL;
        write_reg(blm_pkg::CFG_LOW_LEVEL, CFG_W'(lo));
        write_reg(blm_pkg::CFG_RECOVER_LEVEL, CFG_W'(rec));
        write_reg(blm_pkg::CFG_FULL_LEVEL, CFG_W'(fu));
        write_reg(blm_pkg::CFG_FULL_DROP_LEVEL, CFG_W'(drp));
    endtask

    task automatic configure_phase(input int ph);
        unique case (ph)
            0:
            begin
                write_reg(blm_pkg::CFG_DEBOUNCE_COUNT, CFG_W'(1));
            end
            1:
            begin
                // upper data bits fall outside the 8-bit register: count reads as zero
                write_reg(blm_pkg::CFG_DEBOUNCE_COUNT, {4'($urandom_range(15, 1)), 8'd0});
                write_reg(IDX_W'($urandom_range(7, 5)), CFG_W'($urandom));
            end
            2, 3:
            begin
                write_reg(blm_pkg::CFG_LOW_LEVEL, (ph == 2) ? '0 : CFG_W'(MAX_LEVEL));
                write_reg(blm_pkg::CFG_RECOVER_LEVEL, (ph == 2) ? '0 : CFG_W'(MAX_LEVEL));
                write_reg(blm_pkg::CFG_FULL_LEVEL, (ph == 2) ? '0 : CFG_W'(MAX_LEVEL));
                write_reg(blm_pkg::CFG_FULL_DROP_LEVEL, (ph == 2) ? '0 : CFG_W'(MAX_LEVEL));
                write_reg(blm_pkg::CFG_DEBOUNCE_COUNT, CFG_W'(2));
            end
            4:
            begin
                random_thresholds();
                write_reg(blm_pkg::CFG_DEBOUNCE_COUNT, CFG_W'(blm_pkg::CNT_MAX));
            end
            default:
            begin
                random_thresholds();
                write_reg(blm_pkg::CFG_DEBOUNCE_COUNT, CFG_W'($urandom_range(4, 1)));
                if ($urandom_range(1) == 1)
                    write_reg(IDX_W'($urandom_range(7, 5)), CFG_W'($urandom));
            end
        endcase
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_target();
        unique case ($urandom_range(5))
            0:       return $urandom_range(MAX_SAMPLE);
            1:       return int'(thr_low) - int'($urandom_range(80));
            2:       return int'(thr_recover) + int'($urandom_range(80)) - 40;
            3:       return int'(thr_full) + int'($urandom_range(80));
            4:       return int'(thr_drop) - int'($urandom_range(80));
            default: return int'(thr_low) + int'($urandom_range(60)) - 30;
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] noisy_sample(input int center);
        int v;
        if ($urandom_range(9) == 0)
            v = $urandom_range(MAX_SAMPLE);
        else
            v = center + int'($urandom_range(60)) - 30;
        if (v < 0)
            v = 0;
        if (v > MAX_SAMPLE)
            v = MAX_SAMPLE;
        return v[SAMPLE_BITS-1:0];
    endfunction

    always @(posedge clk)
    begin : check_reports
        level_report_t got;
        level_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[REP_W-1:0];
            reports_seen++;
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("%t unexpected level report, got level %0d flags %b",
                             $realtime, got.level, got.flags);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.level !== want.level || got.flags !== want.flags ||
                    m_tdata[M_W-1:REP_W] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED)
                        $display({"%t report mismatch: level %0d/%0d low %b/%b full %b/%b",
                                  " drop %b/%b shut %b/%b ftmr %b/%b pad %h (exp/got)"},
                                 $realtime, want.level, got.level,
                                 want.flags.battery_low, got.flags.battery_low,
                                 want.flags.battery_full, got.flags.battery_full,
                                 want.flags.drop_charge_full, got.flags.drop_charge_full,
                                 want.flags.restart_shutdown_timer,
                                 got.flags.restart_shutdown_timer,
                                 want.flags.restart_full_timer,
                                 got.flags.restart_full_timer,
                                 m_tdata[M_W-1:REP_W]);
                end
            end
        end
    end

    always @(posedge clk)
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

    initial
    begin : stimulus
        int   target;
        int   span;
        int   sent;
        logic chg_bias;
        logic run_bias;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        beats_in = 0;
        reports_seen = 0;
        reg_writes = 0;
        thr_low = blm_pkg::LOW_LEVEL_RST;
        thr_recover = blm_pkg::RECOVER_LEVEL_RST;
        thr_full = blm_pkg::FULL_LEVEL_RST;
        thr_drop = blm_pkg::FULL_DROP_LEVEL_RST;
        debounce_need = blm_pkg::DEBOUNCE_COUNT_RST;
        frame_pos = 0;
        acc_sum = 0;
        acc_min = 0;
        acc_max = 0;
        low_cnt = '0;
        full_cnt = '0;
        drop_cnt = '0;
        low_on = 1'b0;
        full_on = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].sample, directed_rows[i].charging,
                      directed_rows[i].dev_running, directed_rows[i].checked,
                      {directed_rows[i].exp_flags, directed_rows[i].exp_level});
        wait_drained();

        // steady run with low, below-full and full all met on every frame
        write_reg(blm_pkg::CFG_LOW_LEVEL, CFG_W'(MAX_LEVEL));
        write_reg(blm_pkg::CFG_FULL_LEVEL, '0);
        write_reg(blm_pkg::CFG_FULL_DROP_LEVEL, CFG_W'(MAX_LEVEL));
        write_reg(blm_pkg::CFG_DEBOUNCE_COUNT, CFG_W'(1));
        cfg_we <= 1'b0;
        repeat (STEADY_FRAMES * FRAME_LEN)
            send_beat(SAMPLE_BITS'($urandom_range(MAX_SAMPLE - 1, 1)), 1'b0, 1'b1,
                      1'b0, '0);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            configure_phase(ph);
            unique case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            sent = 0;
            while (sent < PHASE_BEATS)
            begin
                target = pick_target();
                span = $urandom_range(4 * FRAME_LEN, FRAME_LEN);
                chg_bias = 1'($urandom_range(1));
                run_bias = ($urandom_range(3) != 0);
                repeat (span)
                begin
                    send_beat(noisy_sample(target), chg_bias ^ ($urandom_range(7) == 0),
                              run_bias ^ ($urandom_range(7) == 0), 1'b0, '0);
                    sent++;
                end
            end
            wait_drained();
        end

        $display("Covered %0d sample beats, %0d level reports and %0d register writes,",
                 beats_in, reports_seen, reg_writes);
        $display("with zero debounce, threshold extremes and four pacing modes.");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
